// ===== sv/etsh_pkg.sv =====
// Package for the execution-time statistics histogram block.
// Holds the payload and divider structs, register codes and a saturating-increment helper.
// No dependencies.
package etsh_pkg;

    localparam int FINE_STEP_PERCENT_DEF = 5;
    localparam int COARSE_BINS_DEF       = 8;

    localparam int TICK_W     = 32;
    localparam int COUNT_W    = 32;
    localparam int TOTAL_W    = 48;
    localparam int BIN_IDX_W  = 6;
    localparam int NUM_W      = 40;
    localparam int QUOT_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_READ   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY  = 1'b1;

    localparam logic [TICK_W-1:0] PERIOD_RESET = 32'd1000000;
    localparam logic [TICK_W-1:0] DELAY_RESET  = 32'd0;

    typedef struct packed {
        logic                 opcode;
        logic [TICK_W-1:0]    sample_ticks;
        logic [BIN_IDX_W-1:0] bin_index;
    } etsh_in_t;

    typedef struct packed {
        logic [COUNT_W-1:0] sample_count;
        logic [COUNT_W-1:0] overrun_count;
        logic [TICK_W-1:0]  max_ticks;
        logic [TOTAL_W-1:0] total_ticks;
        logic [COUNT_W-1:0] bin_count;
        logic               recorded;
    } etsh_out_t;

    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  numer;
        logic [NUM_W-1:0]  denom;
        logic [QUOT_W-1:0] limit;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } div_rsp_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        logic [COUNT_W-1:0] r;
        r = (v == '1) ? v : v + 1'b1;
        return r;
    endfunction

endpackage

// ===== sv/exec_time_stats_histogram_top.sv =====
// Execution-time statistics histogram, top level.
// Sequencer, counters and configuration; uses etsh_div and etsh_bin_mem.
// Depends on etsh_pkg.
//
// Usage:
//   Input channel in_valid/in_stall/in_data carries one transaction per item:
//   opcode record (sample_ticks) or read (bin_index). The output channel
//   out_valid/out_stall/out_data returns one transaction per item with the
//   counters, the requested bin and the recorded flag.
//   Configuration: cfg_we writes cfg_data into register cfg_index
//   (period_ticks, delay_samples); the user must write only while no item is
//   in flight, as the block does not enforce it. One item is processed at a
//   time; in_stall stays high until it is done. A read fetches its bin, a sample
//   below the delay threshold is only counted, and a recorded sample updates
//   the counters, takes bin 0 or the last coarse bin if the period is zero or
//   else its bin from the repeated-subtraction divider (clamped to 39 fine, 7
//   coarse), then updates the bin. A new item is taken the cycle after the
//   result enters the output register, even while it waits to be taken.
//   A stalled result holds; a finished item waits until the output register
//   frees up. Reset clears all counters and bins and loads default registers.
module exec_time_stats_histogram_top
    import etsh_pkg::*;
#(
    parameter int FINE_STEP_PERCENT = FINE_STEP_PERCENT_DEF,
    parameter int COARSE_BINS       = COARSE_BINS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  etsh_in_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output etsh_out_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int FINE_BINS = (100 / FINE_STEP_PERCENT) * 2;
    localparam int NUM_BINS  = FINE_BINS + COARSE_BINS;
    localparam int AW        = $clog2(NUM_BINS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SETUP,
        S_DIV,
        S_RDBIN,
        S_BIN,
        S_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic                 op_reg, op_next;
    logic [TICK_W-1:0]    d_reg, d_next;
    logic [BIN_IDX_W-1:0] idx_reg, idx_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [COUNT_W-1:0]   overrun_reg, overrun_next;
    logic [TICK_W-1:0]    max_reg, max_next;
    logic [TOTAL_W-1:0]   total_reg, total_next;
    logic [TICK_W-1:0]    period_reg, period_next;
    logic [TICK_W-1:0]    delay_reg, delay_next;
    logic                 coarse_reg, coarse_next;
    logic [NUM_W-1:0]     fsp_reg, fsp_next;
    logic [QUOT_W-1:0]    q_reg, q_next;
    logic [AW-1:0]        addr_reg, addr_next;
    logic [COUNT_W-1:0]   bin_reg, bin_next;
    logic                 rec_reg, rec_next;
    logic                 out_valid_reg, out_valid_next;
    etsh_out_t            out_data_reg, out_data_next;

    logic [COUNT_W-1:0]   count_inc;
    logic [TOTAL_W:0]     sum;
    logic                 in_range;
    logic [AW-1:0]        rd_addr;
    logic                 rd_en;
    logic                 wr_en;
    logic [COUNT_W-1:0]   rd_data;
    div_req_t             div_req;
    div_rsp_t             div_rsp;

    assign count_inc = sat_inc(count_reg);
    assign sum       = {1'b0, total_reg} + (TOTAL_W + 1)'(d_reg);
    assign in_range  = int'(idx_reg) < NUM_BINS;

    always_comb
    begin
        div_req.start = (state_reg == S_SETUP) && (period_reg != '0);
        if (coarse_reg)
        begin
            div_req.numer = NUM_W'({d_reg, 1'b0}) - NUM_W'(period_reg)
                            - NUM_W'({period_reg, 1'b0});
            div_req.denom = NUM_W'({period_reg, 1'b0});
            div_req.limit = QUOT_W'(COARSE_BINS - 1);
        end
        else
        begin
            div_req.numer = NUM_W'(d_reg) * NUM_W'(200) + fsp_reg;
            div_req.denom = {fsp_reg[NUM_W-2:0], 1'b0};
            div_req.limit = QUOT_W'(FINE_BINS - 1);
        end
    end

    always_comb
    begin
        if (op_reg == OP_READ)
        begin
            rd_addr = AW'(idx_reg);
        end
        else if (coarse_reg)
        begin
            rd_addr = AW'(FINE_BINS) + AW'(q_reg);
        end
        else
        begin
            rd_addr = AW'(q_reg);
        end
    end

    assign rd_en = (state_reg == S_RDBIN);
    assign wr_en = (state_reg == S_BIN) && (op_reg == OP_RECORD);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        d_next         = d_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        overrun_next   = overrun_reg;
        max_next       = max_reg;
        total_next     = total_reg;
        period_next    = period_reg;
        delay_next     = delay_reg;
        coarse_next    = coarse_reg;
        fsp_next       = fsp_reg;
        q_next         = q_reg;
        addr_next      = addr_reg;
        bin_next       = bin_reg;
        rec_next       = rec_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PERIOD: period_next = cfg_data;
                CFG_DELAY:  delay_next  = cfg_data;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next  = in_data.opcode;
                    d_next   = in_data.sample_ticks;
                    idx_next = in_data.bin_index;
                    bin_next = '0;
                    rec_next = 1'b0;
                    state_next = (in_data.opcode == OP_READ) ? S_RDBIN : S_LOAD;
                end
            end
            S_LOAD:
            begin
                count_next = count_inc;
                if (count_inc < delay_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    rec_next = 1'b1;
                    if (d_reg > period_reg)
                    begin
                        overrun_next = sat_inc(overrun_reg);
                    end
                    if (d_reg > max_reg)
                    begin
                        max_next = d_reg;
                    end
                    total_next  = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
                    coarse_next = {1'b0, d_reg} > {period_reg, 1'b0};
                    fsp_next    = NUM_W'(period_reg) * NUM_W'(FINE_STEP_PERCENT);
                    state_next  = S_SETUP;
                end
            end
            S_SETUP:
            begin
                if (period_reg == '0)
                begin
                    q_next     = coarse_reg ? QUOT_W'(COARSE_BINS - 1) : '0;
                    state_next = S_RDBIN;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    q_next     = div_rsp.quot;
                    state_next = S_RDBIN;
                end
            end
            S_RDBIN:
            begin
                addr_next  = rd_addr;
                state_next = S_BIN;
            end
            S_BIN:
            begin
                if (op_reg == OP_READ)
                begin
                    bin_next = in_range ? rd_data : '0;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_data_next.sample_count  = count_reg;
                    out_data_next.overrun_count = overrun_reg;
                    out_data_next.max_ticks     = max_reg;
                    out_data_next.total_ticks   = total_reg;
                    out_data_next.bin_count     = bin_reg;
                    out_data_next.recorded      = rec_reg;
                    out_valid_next              = 1'b1;
                    state_next                  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_RECORD;
            d_reg         <= '0;
            idx_reg       <= '0;
            count_reg     <= '0;
            overrun_reg   <= '0;
            max_reg       <= '0;
            total_reg     <= '0;
            period_reg    <= PERIOD_RESET;
            delay_reg     <= DELAY_RESET;
            coarse_reg    <= 1'b0;
            fsp_reg       <= '0;
            q_reg         <= '0;
            addr_reg      <= '0;
            bin_reg       <= '0;
            rec_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            d_reg         <= d_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            overrun_reg   <= overrun_next;
            max_reg       <= max_next;
            total_reg     <= total_next;
            period_reg    <= period_next;
            delay_reg     <= delay_next;
            coarse_reg    <= coarse_next;
            fsp_reg       <= fsp_next;
            q_reg         <= q_next;
            addr_reg      <= addr_next;
            bin_reg       <= bin_next;
            rec_reg       <= rec_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    etsh_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    etsh_bin_mem #(
        .DEPTH (NUM_BINS)
    ) u_bin_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (addr_reg),
        .wr_data (sat_inc(rd_data)),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== sv/etsh_div.sv =====
// Repeated-subtraction divider with a quotient clamp.
// Computes min(numer / denom, limit), one subtraction per cycle.
// Depends on etsh_pkg.
module etsh_div
    import etsh_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    typedef enum logic {
        DV_IDLE,
        DV_RUN
    } dv_state_t;

    dv_state_t         state_reg, state_next;
    logic [NUM_W-1:0]  rem_reg, rem_next;
    logic [NUM_W-1:0]  den_reg, den_next;
    logic [QUOT_W-1:0] lim_reg, lim_next;
    logic [QUOT_W-1:0] quot_reg, quot_next;
    logic              done_reg, done_next;
    logic              step_ok;

    assign step_ok = (quot_reg < lim_reg) && (rem_reg >= den_reg);

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        lim_next   = lim_reg;
        quot_next  = quot_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            DV_IDLE:
            begin
                if (req.start)
                begin
                    rem_next   = req.numer;
                    den_next   = req.denom;
                    lim_next   = req.limit;
                    quot_next  = '0;
                    state_next = DV_RUN;
                end
            end
            DV_RUN:
            begin
                if (step_ok)
                begin
                    rem_next  = rem_reg - den_reg;
                    quot_next = quot_reg + 1'b1;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = DV_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            rem_reg   <= '0;
            den_reg   <= '0;
            lim_reg   <= '0;
            quot_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rem_reg   <= rem_next;
            den_reg   <= den_next;
            lim_reg   <= lim_next;
            quot_reg  <= quot_next;
            done_reg  <= done_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

// ===== sv/etsh_bin_mem.sv =====
// Histogram bin memory: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on etsh_pkg.
module etsh_bin_mem
    import etsh_pkg::*;
#(
    parameter int DEPTH = 48
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [COUNT_W-1:0]       wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [COUNT_W-1:0]       rd_data
);

    logic [COUNT_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]   valid_reg;
    logic [COUNT_W-1:0] rd_data_reg;
    logic               rd_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== sv/etsh_checker.sv =====
// Port-level checks for exec_time_stats_histogram_top, attached by bind.
// Depends on etsh_pkg.
module etsh_checker
    import etsh_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input etsh_out_t out_data
);

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while a transaction is in flight");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled output transaction changed");

    a_bin_zero_on_record: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.recorded |-> out_data.bin_count == '0)
        else $error("recorded sample carries a bin count");

    a_overrun_le_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.overrun_count <= out_data.sample_count)
        else $error("overrun count exceeds sample count");

endmodule

bind exec_time_stats_histogram_top etsh_checker u_etsh_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// ===== dv/etsh_stats_monitor.sv =====
// Monitor for the execution-time statistics histogram block.
// Watches both channels and the register port, predicts each result and compares it.
// Depends on etsh_pkg.
`timescale 1ns / 100ps

module etsh_stats_monitor
    import etsh_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  etsh_in_t              in_data,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  etsh_out_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    error_count,
    output int                    results_due
);

    localparam int FINE_BINS   = (100 / FINE_STEP_PERCENT_DEF) * 2;
    localparam int COARSE_BINS = COARSE_BINS_DEF;
    localparam logic [63:0] TOTAL_MAX = 64'hFFFF_FFFF_FFFF;

    logic [TICK_W-1:0]  period_q;
    logic [TICK_W-1:0]  delay_q;
    logic [COUNT_W-1:0] count_q;
    logic [COUNT_W-1:0] overrun_q;
    logic [TICK_W-1:0]  max_q;
    logic [TOTAL_W-1:0] total_q;
    logic [COUNT_W-1:0] fine_q [FINE_BINS];
    logic [COUNT_W-1:0] coarse_q [COARSE_BINS];

    etsh_out_t stats_due [$];

    initial error_count = 0;

    function automatic logic [COUNT_W-1:0] sat_bump(input logic [COUNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic etsh_out_t predict_stats(input etsh_in_t t);
        etsh_out_t   r;
        logic [63:0] d;
        logic [63:0] p;
        logic [63:0] q;
        logic [63:0] den;
        logic [63:0] sum;
        r = '0;
        if (t.opcode == OP_RECORD)
        begin
            count_q = sat_bump(count_q);
            if (count_q >= delay_q)
            begin
                r.recorded = 1'b1;
                d = 64'(t.sample_ticks);
                p = 64'(period_q);
                if (d > p)
                    overrun_q = sat_bump(overrun_q);
                if (t.sample_ticks > max_q)
                    max_q = t.sample_ticks;
                sum = 64'(total_q) + d;
                total_q = (sum > TOTAL_MAX) ? TOTAL_MAX[TOTAL_W-1:0] : sum[TOTAL_W-1:0];
                if (d > 2 * p)
                begin
                    if (p == 0)
                        q = 64'(COARSE_BINS - 1);
                    else
                    begin
                        q = (2 * d + p) / (2 * p);
                        q = (q < 2) ? 64'd0 : q - 2;
                        if (q > 64'(COARSE_BINS - 1))
                            q = 64'(COARSE_BINS - 1);
                    end
                    coarse_q[int'(q)] = sat_bump(coarse_q[int'(q)]);
                end
                else
                begin
                    den = 64'(FINE_STEP_PERCENT_DEF) * p;
                    if (den == 0)
                        q = 64'd0;
                    else
                    begin
                        q = (200 * d + den) / (2 * den);
                        if (q > 64'(FINE_BINS - 1))
                            q = 64'(FINE_BINS - 1);
                    end
                    fine_q[int'(q)] = sat_bump(fine_q[int'(q)]);
                end
            end
        end
        else if (t.bin_index < FINE_BINS)
            r.bin_count = fine_q[t.bin_index];
        else if (t.bin_index < FINE_BINS + COARSE_BINS)
            r.bin_count = coarse_q[t.bin_index - FINE_BINS];
        r.sample_count  = count_q;
        r.overrun_count = overrun_q;
        r.max_ticks     = max_q;
        r.total_ticks   = total_q;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        etsh_out_t want;
        if (!rst_n)
        begin
            period_q  = PERIOD_RESET;
            delay_q   = DELAY_RESET;
            count_q   = '0;
            overrun_q = '0;
            max_q     = '0;
            total_q   = '0;
            for (int k = 0; k < FINE_BINS; k++)
                fine_q[k] = '0;
            for (int k = 0; k < COARSE_BINS; k++)
                coarse_q[k] = '0;
            stats_due.delete();
            results_due <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PERIOD: period_q = cfg_data;
                    CFG_DELAY:  delay_q  = cfg_data;
                    default:    ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (stats_due.size() == 0)
                begin
                    $error("result transaction with no expected result pending");
                    error_count++;
                end
                else
                begin
                    want = stats_due.pop_front();
                    check_field("sample_count", 64'(want.sample_count),
                                64'(out_data.sample_count));
                    check_field("overrun_count", 64'(want.overrun_count),
                                64'(out_data.overrun_count));
                    check_field("max_ticks", 64'(want.max_ticks), 64'(out_data.max_ticks));
                    check_field("total_ticks", 64'(want.total_ticks),
                                64'(out_data.total_ticks));
                    check_field("bin_count", 64'(want.bin_count), 64'(out_data.bin_count));
                    check_field("recorded", 64'(want.recorded), 64'(out_data.recorded));
                end
            end
            if (in_valid && !in_stall)
                stats_due.push_back(predict_stats(in_data));
            results_due <= stats_due.size();
        end
    end

endmodule

// ===== dv/exec_time_stats_histogram_top_test.sv =====
// Testbench top for the execution-time statistics histogram block.
// Drives reset, registers and transactions with random idling; etsh_stats_monitor checks.
// Depends on etsh_pkg, exec_time_stats_histogram_top and etsh_stats_monitor.
`timescale 1ns / 100ps

module exec_time_stats_histogram_top_test
    import etsh_pkg::*;
();

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 250;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    etsh_in_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    etsh_out_t             out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_PERIOD;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int error_count;
    int results_due;
    int cycle_count   = 0;
    int items_sent    = 0;
    int records_sent  = 0;
    int results_taken = 0;

    exec_time_stats_histogram_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    etsh_stats_monitor u_monitor (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .error_count (error_count),
        .results_due (results_due)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Hold off twice for a long stretch so the block backs up its input.
    always
    begin : result_sink
        int n;
        if (results_taken == 150 || results_taken == 420)
            n = LONG_HOLD;
        else if ((results_taken / 40) % 3 == 2)
            n = 0;
        else
            n = $urandom_range(0, 7);
        if (n > 0)
        begin
            out_stall <= 1'b1;
            repeat (n) @(posedge clk);
        end
        out_stall <= 1'b0;
        @(posedge clk);
        while (!out_valid) @(posedge clk);
        results_taken++;
    end

    task automatic send_txn(input etsh_in_t t);
        int gap;
        gap = ((items_sent / 48) % 3 == 1) ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= t;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
        if (t.opcode == OP_RECORD)
            records_sent++;
    endtask

    task automatic send_record(input logic [TICK_W-1:0] ticks);
        etsh_in_t t;
        t.opcode       = OP_RECORD;
        t.sample_ticks = ticks;
        t.bin_index    = BIN_IDX_W'($urandom_range(0, 63));
        send_txn(t);
    endtask

    task automatic send_read(input logic [BIN_IDX_W-1:0] idx);
        etsh_in_t t;
        t.opcode       = OP_READ;
        t.sample_ticks = $urandom;
        t.bin_index    = idx;
        send_txn(t);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic etsh_in_t rand_item(input logic [TICK_W-1:0] period);
        etsh_in_t    t;
        logic [63:0] p;
        logic [63:0] d;
        int          kind;
        p    = 64'(period);
        kind = $urandom_range(0, 9);
        t.opcode    = ($urandom_range(0, 3) == 0) ? OP_READ : OP_RECORD;
        t.bin_index = BIN_IDX_W'($urandom_range(0, 63));
        case (kind)
            0:       d = 64'($urandom);
            1:       d = 64'($urandom_range(0, 3));
            6, 7, 8: d = 2 * p + 1 + 64'($urandom) % (8 * p + 1);
            9:       d = p * $urandom_range(1, 3) + $urandom_range(0, 2) - 1;
            default: d = 64'($urandom) % (2 * p + 3);
        endcase
        if (d > 64'hFFFF_FFFF)
            d = 64'hFFFF_FFFF;
        t.sample_ticks = d[TICK_W-1:0];
        return t;
    endfunction

    task automatic run_random(input logic [TICK_W-1:0] period, input logic [TICK_W-1:0] delay,
                              input int n);
        wait_drained();
        cfg_write(CFG_PERIOD, period);
        cfg_write(CFG_DELAY, delay);
        repeat (n) send_txn(rand_item(period));
    endtask

    initial
    begin : stimulus
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_record(32'd0);
        send_record(32'd24999);
        send_record(32'd25000);
        send_record(32'd1000000);
        send_record(32'd1000001);
        send_record(32'd2000000);
        send_record(32'd2000001);
        send_record(32'd2500000);
        send_record(32'd9499999);
        send_record(32'hFFFF_FFFF);
        send_read(6'd0);
        send_read(6'd1);
        send_read(6'd20);
        send_read(6'd39);
        send_read(6'd40);
        send_read(6'd41);
        send_read(6'd47);
        send_read(6'd48);
        send_read(6'd63);

        wait_drained();
        cfg_write(CFG_PERIOD, 32'd0);
        send_record(32'd0);
        send_record(32'd5);
        send_record(32'd1);
        send_read(6'd0);
        send_read(6'd47);

        run_random(32'd1, 32'd0, 40);
        run_random(32'hFFFF_FFFF, 32'd0, 40);
        run_random(32'd1000, 32'd0, 120);
        run_random(32'd37, 32'hFFFF_FFFF, 40);
        run_random(32'd37, records_sent + 25, 80);
        run_random(32'd250000, 32'd0, 100);
        run_random(32'd0, 32'd0, 30);
        run_random(32'd20, 32'd0, 100);

        wait_drained();
        repeat (60) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
